// ===== hdl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// Holds operation and status codes, field widths and the controller state type.
// No dependencies.
package skt_pkg;

   localparam int KEY_W   = 32;
   localparam int MODE_W  = 2;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;

   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_DUP    = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd3;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PROBE  = 6'b000010,
      S_CMP    = 6'b000100,
      S_DECIDE = 6'b001000,
      S_SHIFT  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

endpackage

// ===== hdl/skt_key_ram.sv =====
// Key store of the sorted key table: one write port, one read port.
// Read data is registered. Depends on skt_pkg.
module skt_key_ram
   import skt_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [KEY_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [KEY_W-1:0]  rd_data
);

   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sorted_key_table.sv =====
// Sorted key table: ordered store of distinct signed keys with search, insert, remove.
// Controller and binary search around skt_key_ram. Depends on skt_pkg.
//
//   channel   handshake         fields
//   request   start / busy      req_mode, req_key
//   response  rsp_valid strobe  rsp_status, rsp_position, rsp_entry_count
//
// Binary search: each probe is a read (S_PROBE) then a compare (S_CMP), at most ceil(log2(n+1)) probes,
// plus a final S_PROBE when the range empties, then S_DECIDE.
// Insert and remove then move one key per cycle in S_SHIFT, which also drains the last move,
// then S_FINISH writes the new key or lowers the count and raises the strobe.
// Reset clears the key count and the control state; the store is never cleared.
// Responses last one cycle and cannot be stalled; busy stays high until the strobe.
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic signed [KEY_W-1:0]  req_key,
   output logic                     rsp_valid,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [POS_W-1:0]         rsp_position,
   output logic [COUNT_W-1:0]       rsp_entry_count
);

   localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic found_ff, found_in;

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic move_ff, move_in;
   logic [IDX_W-1:0] move_addr_ff, move_addr_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [POS_W-1:0] position_ff, position_in;

   logic ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [KEY_W-1:0] ram_wr_data;
   logic ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [KEY_W-1:0] ram_rd_data;

   logic [CNT_W-1:0] span;
   logic [CNT_W-1:0] mid_full;
   logic signed [KEY_W-1:0] probe;
   logic is_insert;

   skt_key_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign span      = hi_ff - lo_ff - CNT_W'(1);
   assign mid_full  = lo_ff + (span >> 1);
   assign probe     = $signed(ram_rd_data);
   assign is_insert = (mode_ff == MODE_INSERT);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      found_in     = found_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rem_in       = rem_ff;
      ptr_in       = ptr_ff;
      move_in      = 1'b0;
      move_addr_in = move_addr_ff;
      status_in    = status_ff;
      position_in  = position_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = move_addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = mid_full[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               key_in   = req_key;
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff >= hi_ff) begin
               state_in = S_DECIDE;
            end else begin
               ram_rd_en = 1'b1;
               mid_in    = mid_full[IDX_W-1:0];
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            if (key_ff > probe) begin
               lo_in    = CNT_W'(mid_ff) + CNT_W'(1);
               state_in = S_PROBE;
            end else if (key_ff < probe) begin
               hi_in    = CNT_W'(mid_ff);
               state_in = S_PROBE;
            end else begin
               found_in = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            position_in = '0;
            if (is_insert) begin
               if (found_ff) begin
                  status_in    = STATUS_DUP;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else if (CNT_W'(CAPACITY) <= count_ff) begin
                  status_in    = STATUS_FULL;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  status_in = STATUS_OK;
                  rem_in    = count_ff - lo_ff;
                  ptr_in    = IDX_W'(count_ff - CNT_W'(1));
                  state_in  = S_SHIFT;
               end
            end else if (mode_ff == MODE_REMOVE) begin
               if (!found_ff) begin
                  status_in    = STATUS_ABSENT;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  status_in = STATUS_OK;
                  rem_in    = count_ff - CNT_W'(mid_ff) - CNT_W'(1);
                  ptr_in    = mid_ff + IDX_W'(1);
                  state_in  = S_SHIFT;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (found_ff) begin
                  status_in   = STATUS_OK;
                  position_in = POS_W'(mid_ff);
               end else begin
                  status_in = STATUS_ABSENT;
               end
            end
         end
         S_SHIFT: begin
            // drain the move whose read was issued last cycle
            ram_wr_en = move_ff;
            if (rem_ff != '0) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff;
               move_in     = 1'b1;
               rem_in      = rem_ff - CNT_W'(1);
               if (is_insert) begin
                  move_addr_in = ptr_ff + IDX_W'(1);
                  ptr_in       = ptr_ff - IDX_W'(1);
               end else begin
                  move_addr_in = ptr_ff - IDX_W'(1);
                  ptr_in       = ptr_ff + IDX_W'(1);
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (is_insert) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = lo_ff[IDX_W-1:0];
               ram_wr_data = key_ff;
               count_in    = count_ff + CNT_W'(1);
               position_in = POS_W'(lo_ff);
            end else begin
               count_in    = count_ff - CNT_W'(1);
               position_in = POS_W'(mid_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         move_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         move_ff      <= move_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      rem_ff       <= rem_in;
      ptr_ff       <= ptr_in;
      move_addr_ff <= move_addr_in;
      status_ff    <= status_in;
      position_ff  <= position_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = position_ff;
   assign rsp_entry_count = COUNT_W'(count_ff);

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("key count beyond capacity");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("response strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted but not busy");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != STATUS_OK)) |-> (position_ff == '0))
      else $error("position not zero on failed operation");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && is_insert && (status_ff == STATUS_OK))
         |-> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("insert did not grow the count");
`endif

endmodule
